@@ rtl/core/sfmd_pkg.sv @@
// ---------------------------------------------------------------------------
// Framed message deframer package
// Shared types and constants for the deframer front end, queue and back end.
// ---------------------------------------------------------------------------
package sfmd_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
	localparam logic [1:0] REG_MAX_BODY_LEN = 2'd2;

	// Configuration reset values.
	localparam logic [7:0] SYNC_FIRST_RST   = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST  = 8'h55;
	localparam logic [7:0] MAX_BODY_LEN_RST = 8'd58;

	// Fixed frame positions.
	localparam logic [8:0] POS_OPCODE = 9'd0;
	localparam logic [8:0] POS_LENGTH = 9'd1;
	localparam logic [8:0] POS_BODY   = 9'd2;

	// Result queue geometry.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Parser phase, one-hot.
	typedef enum logic [5:0] {
		PH_SYNC1  = 6'b000001,
		PH_SYNC2  = 6'b000010,
		PH_OPCODE = 6'b000100,
		PH_LENGTH = 6'b001000,
		PH_BODY   = 6'b010000,
		PH_CHECK  = 6'b100000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [8:0] byte_index;
		logic       frame_end;
		logic       checksum_ok;
		logic       too_long;
	} res_t;

	// Write side of the result queue.
	typedef struct packed {
		logic valid;
		res_t data;
	} q_push_t;

	// Read side of the result queue.
	typedef struct packed {
		logic valid;
		res_t data;
	} q_head_t;

endpackage

@@ rtl/core/sfmd_front.sv @@
// ---------------------------------------------------------------------------
// Deframer front end
// Holds the configuration, parses received bytes and queues result items.
// ---------------------------------------------------------------------------
module sfmd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_wdata,
	input  logic             rx_valid,
	output logic             rx_ready,
	input  logic [7:0]       rx_byte,
	input  logic             q_full,
	output sfmd_pkg::q_push_t push
);
	import sfmd_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] max_body_len_q;

	phase_t     phase_q, phase_d;
	logic [8:0] pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;

	logic       accept;
	logic       emit;
	res_t       res;
	logic [8:0] body_off;
	logic [8:0] body_end;

	// A request is taken whenever the queue has room.
	assign rx_ready = !q_full;
	assign accept   = rx_valid && rx_ready;

	assign body_off = pos_q - POS_BODY;
	assign body_end = {1'b0, len_q} + POS_BODY;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= SYNC_FIRST_RST;
			sync_second_q  <= SYNC_SECOND_RST;
			max_body_len_q <= MAX_BODY_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:   sync_first_q   <= cfg_wdata;
				REG_SYNC_SECOND:  sync_second_q  <= cfg_wdata;
				REG_MAX_BODY_LEN: max_body_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next parser state and the result item for the current byte.
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		sum_d   = sum_q;
		emit    = 1'b0;
		res     = '0;
		res.out_byte = rx_byte;
		case (phase_q)
			PH_SYNC2: begin
				pos_d   = '0;
				sum_d   = '0;
				phase_d = (rx_byte == sync_second_q) ? PH_OPCODE : PH_SYNC1;
			end
			PH_OPCODE: begin
				sum_d          = rx_byte;
				emit           = 1'b1;
				res.byte_index = POS_OPCODE;
				pos_d          = POS_LENGTH;
				phase_d        = PH_LENGTH;
			end
			PH_LENGTH: begin
				sum_d          = sum_q + rx_byte;
				len_d          = rx_byte;
				emit           = 1'b1;
				res.byte_index = POS_LENGTH;
				pos_d          = POS_BODY;
				phase_d        = (rx_byte == 8'd0) ? PH_CHECK : PH_BODY;
			end
			PH_BODY: begin
				// Bytes past the limit still count in the sum but are not passed on.
				sum_d          = sum_q + rx_byte;
				emit           = (body_off < {1'b0, max_body_len_q});
				res.byte_index = pos_q;
				pos_d          = pos_q + 9'd1;
				if (pos_d >= body_end) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				emit            = 1'b1;
				res.byte_index  = POS_OPCODE;
				res.frame_end   = 1'b1;
				res.checksum_ok = (rx_byte == sum_q);
				res.too_long    = (len_q > max_body_len_q);
				pos_d           = '0;
				phase_d         = PH_SYNC1;
			end
			default: begin
				phase_d = (rx_byte == sync_first_q) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	end

	// Parser state advances on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			pos_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
		end
	end

	assign push.valid = accept && emit;
	assign push.data  = res;

`ifndef ASSERT_OFF
	// The checksum byte always sends the parser back to the hunt.
	a_check_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_CHECK) |=> (phase_q == PH_SYNC1))
		else $error("parser did not return to hunt after checksum byte");

	// Sync bytes never produce a result.
	a_sync_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYNC1 || phase_q == PH_SYNC2) |-> !push.valid)
		else $error("result produced for a sync byte");

	// Flags appear only on the frame end result, which carries index zero.
	a_flags_end: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !push.data.frame_end) |->
		(!push.data.checksum_ok && !push.data.too_long))
		else $error("status flags set on a non-final result");

	// Body position stays inside the declared length.
	a_body_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (pos_q < body_end))
		else $error("body position beyond frame length");
`endif

endmodule

@@ rtl/core/sfmd_queue.sv @@
// ---------------------------------------------------------------------------
// Deframer result queue
// Short FIFO that lets the parser and the output stage stall independently.
// ---------------------------------------------------------------------------
module sfmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  sfmd_pkg::q_push_t push,
	output logic              full,
	output sfmd_pkg::q_head_t head,
	input  logic              pop
);
	import sfmd_pkg::*;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && (count_q != '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_ptr_q];

`ifndef ASSERT_OFF
	// The fill level never exceeds the depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue fill level above depth");

	// The parser never pushes into a full queue, so no result is dropped.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full))
		else $error("push into full queue");

	// Pointers differ by the fill level, so they are equal when the queue is empty or full.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers inconsistent with fill level");
`endif

endmodule

@@ rtl/core/sfmd_back.sv @@
// ---------------------------------------------------------------------------
// Deframer back end
// Output register that drains the result queue onto the result channel.
// ---------------------------------------------------------------------------
module sfmd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sfmd_pkg::q_head_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output sfmd_pkg::res_t    res
);
	import sfmd_pkg::*;

	logic out_valid_q;
	res_t res_q;

	// Load a new result when the register is empty or its request is taken.
	assign pop = head.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= head.valid;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head.data;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	// A queued result reaches the output in the next cycle when the register is free.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped result not presented");

	// The register is never overwritten while its request waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !pop)
		else $error("pending result overwritten");

	// An empty register with a waiting result always loads it.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && head.valid) |-> pop)
		else $error("output stage idle while results wait");
`endif

endmodule

@@ rtl/core/sync_framed_message_deframer_core.sv @@
// ---------------------------------------------------------------------------
// Framed message deframer core
// Hunts for two sync bytes, then passes opcode, length and body bytes on with
// their positions and closes each frame with checksum and length status.
// ---------------------------------------------------------------------------
// A result is written into the queue when its byte is accepted, then loaded
// into the output register, where it waits until out_ready takes it.
// Throughput: one byte per cycle while the queue is not full; a four-entry
// queue feeds the output register and the parser updates state and 8-bit sum.
// Reset clears the parser to the hunt, empties the queue and the output
// register, and loads the sync bytes 0xAA and 0x55 and a body limit of 58.
module sync_framed_message_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [8:0] byte_index,
	output logic       frame_end,
	output logic       checksum_ok,
	output logic       too_long
);
	import sfmd_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;
	res_t    res;

	// Parser and configuration.
	sfmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.push      (push)
	);

	// Result queue between parser and output.
	sfmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// Output stage.
	sfmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign out_byte    = res.out_byte;
	assign byte_index  = res.byte_index;
	assign frame_end   = res.frame_end;
	assign checksum_ok = res.checksum_ok;
	assign too_long    = res.too_long;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Framed message deframer testbench
// Sends byte requests to the deframer core, predicts results from an internal
// deframing model or fixed table rows and compares field by field in order.
// A short directed table comes first, then random frames with noise under
// several register settings and idle patterns.
// ---------------------------------------------------------------------------
module tb_top;
	import sfmd_pkg::*;

	// How the expectation for one byte request is formed.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_FIXED
	} check_mode_t;

	// Kinds of directed table rows.
	typedef enum logic {
		ROW_BYTE,
		ROW_LIMIT
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		check_mode_t mode;
		logic [7:0]  value;
		res_t        fixed;
	} dir_row_t;

	typedef struct packed {
		check_mode_t mode;
		res_t        fixed;
	} rx_plan_t;

	localparam res_t NO_RES = '0;
	localparam int N_DIRECTED = 30;
	localparam int PHASE_BYTES = 36;

	// Directed rows: hunt noise, zero length, bad checksum, wrong second sync,
	// body beyond the limit, and a frame checked against the predictor.
	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ROW_BYTE,  CHK_NONE,  8'h55, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'hAA, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'h55, NO_RES},
		'{ROW_BYTE,  CHK_FIXED, 8'hFF, '{8'hFF, 9'd0, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_FIXED, 8'h00, '{8'h00, 9'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_FIXED, 8'hFF, '{8'hFF, 9'd0, 1'b1, 1'b1, 1'b0}},
		'{ROW_BYTE,  CHK_NONE,  8'hAA, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'h55, NO_RES},
		'{ROW_BYTE,  CHK_FIXED, 8'h01, '{8'h01, 9'd0, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_FIXED, 8'h01, '{8'h01, 9'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_FIXED, 8'hFF, '{8'hFF, 9'd2, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_FIXED, 8'h00, '{8'h00, 9'd0, 1'b1, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_NONE,  8'hAA, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'hAA, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'h55, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'hAA, NO_RES},
		'{ROW_BYTE,  CHK_NONE,  8'h55, NO_RES},
		'{ROW_LIMIT, CHK_NONE,  8'h00, NO_RES},
		'{ROW_BYTE,  CHK_FIXED, 8'h80, '{8'h80, 9'd0, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_FIXED, 8'h01, '{8'h01, 9'd1, 1'b0, 1'b0, 1'b0}},
		'{ROW_BYTE,  CHK_NONE,  8'h7F, NO_RES},
		'{ROW_BYTE,  CHK_FIXED, 8'h00, '{8'h00, 9'd0, 1'b1, 1'b1, 1'b1}},
		'{ROW_LIMIT, CHK_NONE,  8'h01, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'hAA, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'h55, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'h3C, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'h02, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'h11, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'h22, NO_RES},
		'{ROW_BYTE,  CHK_MODEL, 8'hA6, NO_RES}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_SYNC_FIRST;
	logic [7:0] cfg_wdata = 8'h00;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [8:0] byte_index;
	logic       frame_end;
	logic       checksum_ok;
	logic       too_long;

	// Predictor copy of the registers and the parser state.
	logic [7:0] reg_sync_first = SYNC_FIRST_RST;
	logic [7:0] reg_sync_second = SYNC_SECOND_RST;
	logic [7:0] reg_max_body = MAX_BODY_LEN_RST;
	phase_t     prs_phase = PH_SYNC1;
	logic [8:0] prs_pos = 9'd0;
	logic [7:0] prs_len = 8'd0;
	logic [7:0] prs_sum = 8'd0;

	// Register values as seen by the frame generator.
	logic [7:0] gen_sync_first = SYNC_FIRST_RST;
	logic [7:0] gen_sync_second = SYNC_SECOND_RST;
	logic [7:0] gen_max_body = MAX_BODY_LEN_RST;

	rx_plan_t rx_plan_q [$];
	res_t     deframed_q [$];
	int       fail_count = 0;
	int       bytes_sent = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;

	sync_framed_message_deframer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_index  (byte_index),
		.frame_end   (frame_end),
		.checksum_ok (checksum_ok),
		.too_long    (too_long)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the predicted parser by one byte and return its result, if any.
	function automatic void deframe_byte(input logic [7:0] b, output logic emitted,
			output res_t r);
		logic [8:0] offset;
		emitted = 1'b0;
		r = '0;
		offset = prs_pos - POS_BODY;
		case (prs_phase)
		PH_SYNC2: begin
			prs_pos = 9'd0;
			prs_sum = 8'd0;
			prs_phase = (b == reg_sync_second) ? PH_OPCODE : PH_SYNC1;
		end
		PH_OPCODE: begin
			prs_sum = b;
			r.out_byte = b;
			r.byte_index = POS_OPCODE;
			emitted = 1'b1;
			prs_pos = POS_LENGTH;
			prs_phase = PH_LENGTH;
		end
		PH_LENGTH: begin
			prs_sum = prs_sum + b;
			prs_len = b;
			r.out_byte = b;
			r.byte_index = POS_LENGTH;
			emitted = 1'b1;
			prs_pos = POS_BODY;
			prs_phase = (b == 8'd0) ? PH_CHECK : PH_BODY;
		end
		PH_BODY: begin
			// Bytes past the limit still count toward the sum.
			prs_sum = prs_sum + b;
			if (offset < {1'b0, reg_max_body}) begin
				r.out_byte = b;
				r.byte_index = prs_pos;
				emitted = 1'b1;
			end
			prs_pos = prs_pos + 9'd1;
			if (prs_pos >= ({1'b0, prs_len} + 9'd2))
				prs_phase = PH_CHECK;
		end
		PH_CHECK: begin
			r.out_byte = b;
			r.byte_index = 9'd0;
			r.frame_end = 1'b1;
			r.checksum_ok = (b == prs_sum);
			r.too_long = (prs_len > reg_max_body);
			emitted = 1'b1;
			prs_phase = PH_SYNC1;
			prs_pos = 9'd0;
		end
		default: begin
			prs_phase = (b == reg_sync_first) ? PH_SYNC2 : PH_SYNC1;
		end
		endcase
	endfunction

	function automatic logic same_result(input res_t a, input res_t b);
		return (a.out_byte === b.out_byte) && (a.byte_index === b.byte_index) &&
			(a.frame_end === b.frame_end) && (a.checksum_ok === b.checksum_ok) &&
			(a.too_long === b.too_long);
	endfunction

	function automatic void note_failure(input string what);
		if (fail_count < 10)
			$display("ERROR: %s", what);
		fail_count++;
	endfunction

	// Register writes and accepted requests feed the predictor; accepted
	// results are checked against the oldest prediction.
	always @(posedge clk) begin : scoreboard
		rx_plan_t plan;
		res_t     predicted;
		res_t     seen;
		logic     emitted;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
				REG_SYNC_FIRST:   reg_sync_first = cfg_wdata;
				REG_SYNC_SECOND:  reg_sync_second = cfg_wdata;
				REG_MAX_BODY_LEN: reg_max_body = cfg_wdata;
				default: ;
				endcase
			end
			if (rx_valid && rx_ready) begin
				plan = rx_plan_q.pop_front();
				deframe_byte(rx_byte, emitted, predicted);
				if (plan.mode == CHK_FIXED)
					deframed_q.push_back(plan.fixed);
				else if (plan.mode == CHK_MODEL && emitted)
					deframed_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				seen.out_byte = out_byte;
				seen.byte_index = byte_index;
				seen.frame_end = frame_end;
				seen.checksum_ok = checksum_ok;
				seen.too_long = too_long;
				if (deframed_q.size() == 0) begin
					note_failure($sformatf("unexpected result byte=%02h index=%0d end=%b",
						out_byte, byte_index, frame_end));
				end else begin
					predicted = deframed_q.pop_front();
					if (!same_result(predicted, seen))
						note_failure($sformatf({"result mismatch: expected byte=%02h ",
							"index=%0d end=%b ok=%b long=%b, got byte=%02h index=%0d ",
							"end=%b ok=%b long=%b"}, predicted.out_byte,
							predicted.byte_index, predicted.frame_end,
							predicted.checksum_ok, predicted.too_long, seen.out_byte,
							seen.byte_index, seen.frame_end, seen.checksum_ok,
							seen.too_long));
				end
			end
		end
	end

	// Result side stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offer one byte request after a random gap and wait until it is taken.
	task automatic send_byte(input logic [7:0] b, input check_mode_t mode, input res_t fixed);
		rx_plan_t plan;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		plan.mode = mode;
		plan.fixed = fixed;
		rx_plan_q.push_back(plan);
		rx_valid <= 1'b1;
		rx_byte <= b;
		bytes_sent++;
		do @(posedge clk); while (!rx_ready);
	endtask

	// Stop sending and wait until every predicted result has come out.
	task automatic settle_block();
		rx_valid <= 1'b0;
		do @(posedge clk); while (deframed_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_wdata <= second;
		@(posedge clk);
		cfg_index <= REG_MAX_BODY_LEN;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_sync_first = first;
		gen_sync_second = second;
		gen_max_body = lim;
	endtask

	// One well-formed frame with random content; the checksum is mostly right.
	task automatic send_frame(input logic [7:0] len);
		logic [7:0] op;
		logic [7:0] body;
		logic [7:0] sum;
		logic [7:0] chk;
		op = 8'($urandom_range(255));
		send_byte(gen_sync_first, CHK_MODEL, NO_RES);
		send_byte(gen_sync_second, CHK_MODEL, NO_RES);
		send_byte(op, CHK_MODEL, NO_RES);
		send_byte(len, CHK_MODEL, NO_RES);
		sum = op + len;
		repeat (len) begin
			body = 8'($urandom_range(255));
			sum = sum + body;
			send_byte(body, CHK_MODEL, NO_RES);
		end
		chk = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : sum;
		send_byte(chk, CHK_MODEL, NO_RES);
	endtask

	initial begin : stimulus
		int         pick;
		int         tmp;
		int         phase_start;
		int         spins;
		logic [7:0] len;
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] lim;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_LIMIT) begin
				settle_block();
				set_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, DIRECTED_ROWS[i].value);
			end else begin
				send_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].mode,
					DIRECTED_ROWS[i].fixed);
			end
		end

		// Random phases, each with its own registers and idle pattern.
		for (int p = 0; p < 4; p++) begin
			settle_block();
			case (p)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
				first = SYNC_FIRST_RST;
				second = SYNC_SECOND_RST;
				lim = MAX_BODY_LEN_RST;
			end
			1: begin
				send_idle_pct = 69;
				stall_pct = 0;
				first = 8'h00;
				second = 8'hFF;
				lim = 8'h00;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 69;
				first = 8'hFF;
				second = 8'h00;
				lim = 8'hFF;
			end
			default: begin
				send_idle_pct = 34;
				stall_pct = 34;
				first = 8'($urandom_range(255));
				second = 8'($urandom_range(255));
				lim = 8'($urandom_range(12));
			end
			endcase
			set_regs(first, second, lim);
			// The widest limit gets one frame of the longest body.
			if (gen_max_body == 8'hFF)
				send_frame(8'hFF);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					repeat ($urandom_range(4, 1))
						send_byte(8'($urandom_range(255)), CHK_MODEL, NO_RES);
				end else if (pick < 16) begin
					// First sync followed by anything but the second sync.
					send_byte(gen_sync_first, CHK_MODEL, NO_RES);
					send_byte(gen_sync_second ^ 8'($urandom_range(255, 1)), CHK_MODEL,
						NO_RES);
				end else if (pick < 18) begin
					settle_block();
				end else begin
					tmp = $urandom_range(39);
					if (tmp < 26 || (tmp < 38 && gen_max_body > 8'd64)) begin
						len = 8'($urandom_range(6));
					end else if (tmp < 38) begin
						tmp = int'(gen_max_body) + int'($urandom_range(2)) - 1;
						len = (tmp < 0) ? 8'd0 : 8'(tmp);
					end else begin
						len = 8'($urandom_range(255));
					end
					send_frame(len);
				end
			end
		end

		// Drain what is left, within a bound.
		rx_valid <= 1'b0;
		spins = 0;
		while (deframed_q.size() != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);
		if (deframed_q.size() != 0) begin
			$display("ERROR: %0d predicted results never arrived", deframed_q.size());
			fail_count += deframed_q.size();
		end
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard stop in case a handshake hangs.
	initial begin
		#4_000_000;
		$display("ERROR: run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
